### design/irs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irs_pkg
// Shared types and constants of the integer run sorter.
// ----------------------------------------------------------------------------
package irs_pkg;

    localparam int DATA_W            = 64;
    localparam int MAX_ITEMS_DEFAULT = 64;

    // One sorting cell's contents.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
    } cell_data_t;

    // Operation applied to the whole cell row at once.
    typedef enum logic [1:0] {
        OP_HOLD     = 2'd0,
        OP_INSERT   = 2'd1,
        OP_SHIFT_DN = 2'd2,
        OP_SHIFT_UP = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage : irs_pkg
`default_nettype wire

### design/irs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irs_cell
// One sorting cell: holds a value, compares it with the broadcast input and
// takes the input or a neighbour's contents to insert in order or to shift.
// ----------------------------------------------------------------------------
module irs_cell
    import irs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_op_t          op,
    input  wire logic [DATA_W-1:0] new_value,
    input  wire cell_data_t        lower_data,
    input  wire logic              lower_gt,
    input  wire cell_data_t        upper_data,
    output      cell_data_t        data,
    output      logic              gt
);

    cell_data_t data_reg;
    cell_data_t data_next;

    // An empty cell counts as larger than anything, so empty cells stay on top.
    assign gt   = !data_reg.valid || ($signed(data_reg.value) > $signed(new_value));
    assign data = data_reg;

    always_comb begin
        data_next = data_reg;
        case (op)
            OP_INSERT: begin
                if (gt) begin
                    if (lower_gt) begin
                        data_next = lower_data;
                    end else begin
                        data_next.valid = 1'b1;
                        data_next.value = new_value;
                    end
                end
            end
            OP_SHIFT_DN: data_next = upper_data;
            OP_SHIFT_UP: data_next = lower_data;
            default:     data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg.value <= data_next.value;
        if (!aresetn) begin
            data_reg.valid <= 1'b0;
        end else begin
            data_reg.valid <= data_next.valid;
        end
    end

endmodule : irs_cell
`default_nettype wire

### design/integer_run_sorter_unit.sv
`default_nettype none
// Draining starts after the final item's transfer. Sorting ascending, the first result
// enters the output register once that register is free; sorting descending, the row first
// shifts up while the register is free until its top cell is filled. Throughput: one item
// per cycle while a run is collected, and one result per cycle while it drains and the
// output register is free; the next run is taken once the final result has entered it.
// Reset (synchronous, active low) empties the row and clears the item count.
// ----------------------------------------------------------------------------
// integer_run_sorter_unit
// Collects a run of signed 64-bit values in a row of insertion-sorting cells
// and emits the run in ascending or descending order after its final item.
// ----------------------------------------------------------------------------
module integer_run_sorter_unit
    import irs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration: bit 0 selects descending order.
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    // Input channel.
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire logic [DATA_W-1:0] s_value,
    input  wire logic              s_last_in,
    // Result channel.
    output      logic              m_valid,
    input  wire logic              m_ready,
    output      logic [DATA_W-1:0] m_sorted_value,
    output      logic              m_last_out,
    output      logic              m_overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    // Control state.
    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  remain_reg,    remain_next;
    logic              ovf_reg,       ovf_next;
    logic              ovf_run_reg,   ovf_run_next;
    logic              desc_cfg_reg;
    logic              desc_run_reg,  desc_run_next;

    // Output register.
    logic              m_valid_reg,   m_valid_next;
    logic [DATA_W-1:0] m_value_reg,   m_value_next;
    logic              m_last_reg,    m_last_next;
    logic              m_ovf_reg,     m_ovf_next;

    // Cell row.
    cell_op_t          row_op;
    cell_data_t        cell_q  [MAX_ITEMS];
    logic              cell_gt [MAX_ITEMS];
    cell_data_t        end_cell;

    logic              in_xfer;
    logic              room;
    logic              out_free;
    logic              emit;

    assign s_ready  = (state_reg == ST_FILL);
    assign in_xfer  = s_valid && s_ready;
    assign room     = (count_reg < CNT_W'(MAX_ITEMS));
    assign out_free = !m_valid_reg || m_ready;

    // Ascending runs leave from the bottom cell, descending ones from the top.
    assign end_cell = desc_run_reg ? cell_q[MAX_ITEMS-1] : cell_q[0];
    assign emit     = (state_reg == ST_DRAIN) && out_free && end_cell.valid;

    // The row is kept ascending from cell 0 upward with empty cells on top. A
    // new value is inserted while there is room; while draining, the row shifts down
    // (ascending) or up (descending) each cycle the output register is free.
    always_comb begin
        row_op = OP_HOLD;
        if (in_xfer && room) begin
            row_op = OP_INSERT;
        end else if ((state_reg == ST_DRAIN) && out_free) begin
            row_op = desc_run_reg ? OP_SHIFT_UP : OP_SHIFT_DN;
        end
    end

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        cell_data_t lower_d;
        cell_data_t upper_d;
        logic       lower_g;

        if (i == 0) begin : g_bottom
            assign lower_d = '0;
            assign lower_g = 1'b0;
        end else begin : g_lower
            assign lower_d = cell_q[i-1];
            assign lower_g = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_top
            assign upper_d = '0;
        end else begin : g_upper
            assign upper_d = cell_q[i+1];
        end

        irs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (row_op),
            .new_value  (s_value),
            .lower_data (lower_d),
            .lower_gt   (lower_g),
            .upper_data (upper_d),
            .data       (cell_q[i]),
            .gt         (cell_gt[i])
        );
    end

    // Run control: counting, overflow tracking and the switch to draining.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        ovf_next      = ovf_reg;
        ovf_run_next  = ovf_run_reg;
        desc_run_next = desc_run_reg;
        case (state_reg)
            ST_FILL: begin
                if (in_xfer) begin
                    if (s_last_in) begin
                        // The final item still counts towards overflow.
                        state_next    = ST_DRAIN;
                        remain_next   = count_reg + CNT_W'(room);
                        ovf_run_next  = ovf_reg || !room;
                        desc_run_next = desc_cfg_reg;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                    end else if (room) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (emit) begin
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = ST_FILL;
                    end
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // Output register: a result waits here until it is taken, and the row holds while it waits.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_value_next = end_cell.value;
            m_last_next  = (remain_reg == CNT_W'(1));
            m_ovf_next   = ovf_run_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
        m_ovf_reg    <= m_ovf_next;
        remain_reg   <= remain_next;
        ovf_run_reg  <= ovf_run_next;
        desc_run_reg <= desc_run_next;
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            desc_cfg_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                desc_cfg_reg <= cfg_wr_data;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_last_out     = m_last_reg;
    assign m_overflow     = m_ovf_reg;

endmodule : integer_run_sorter_unit
`default_nettype wire

### verif/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer run sorter testbench
// Sends runs of signed 64-bit values to integer_run_sorter_unit and checks each
// sorted result against a behavioural predictor held in a scoreboard class.
// The runs include corner values, duplicates, single-value runs, full runs and
// runs beyond capacity, in both sort orders. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module testbench
    import irs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RUN_DEPTH   = MAX_ITEMS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned PHASE_SIZE  = 105;
    localparam int          PHASES      = 4;

    // Values of the order register.
    localparam logic ORDER_ASCENDING  = 1'b0;
    localparam logic ORDER_DESCENDING = 1'b1;

    localparam logic [DATA_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Corner values sent as one run in the directed part, in both orders.
    localparam logic [DATA_W-1:0] CORNER_VALUES [8] = '{
        VAL_MAX, VAL_MIN, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
        64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
    };

    // The scoreboard mirrors the sorter: it collects each run as its values are
    // transferred, and when the final value arrives it sorts the held values
    // and queues one expected result per held value.
    class sort_scoreboard;
        typedef struct {
            logic [DATA_W-1:0] value;
            logic              last;
            logic              overflow;
        } sorted_result_t;

        logic [DATA_W-1:0] run_store [RUN_DEPTH];
        int unsigned       run_count;
        bit                run_dropped;
        logic              descending;
        sorted_result_t    awaited [$];
        int unsigned       failures;
        int unsigned       results_checked;
        int unsigned       runs_closed;
        int unsigned       overflow_runs;

        function new();
            run_count       = 0;
            run_dropped     = 1'b0;
            descending      = ORDER_ASCENDING;
            failures        = 0;
            results_checked = 0;
            runs_closed     = 0;
            overflow_runs   = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // True when a must be emitted after b in the selected order.
        function bit goes_later(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            if (descending == ORDER_DESCENDING) begin
                return $signed(a) < $signed(b);
            end
            return $signed(a) > $signed(b);
        endfunction

        function void note_input(logic [DATA_W-1:0] value, logic last);
            logic [DATA_W-1:0] row [RUN_DEPTH];
            logic [DATA_W-1:0] cur;
            sorted_result_t    res;
            int                i;
            int                j;
            // A full store drops the value, the final one included.
            if (run_count < RUN_DEPTH) begin
                run_store[run_count] = value;
                run_count++;
            end else begin
                run_dropped = 1'b1;
            end
            if (!last) begin
                return;
            end
            for (i = 0; i < run_count; i++) begin
                row[i] = run_store[i];
            end
            for (i = 1; i < run_count; i++) begin
                cur = row[i];
                j   = i;
                while (j > 0 && goes_later(row[j-1], cur)) begin
                    row[j] = row[j-1];
                    j--;
                end
                row[j] = cur;
            end
            for (i = 0; i < run_count; i++) begin
                res.value    = row[i];
                res.last     = (i == run_count - 1);
                res.overflow = run_dropped;
                awaited.push_back(res);
            end
            runs_closed++;
            if (run_dropped) begin
                overflow_runs++;
            end
            run_count   = 0;
            run_dropped = 1'b0;
        endfunction

        function void flag(string what, logic [DATA_W-1:0] expected, logic [DATA_W-1:0] actual);
            failures++;
            if (failures <= 100) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, $signed(expected), $signed(actual));
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] value, logic last, logic overflow);
            sorted_result_t exp_res;
            results_checked++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 100) begin
                    $display("%0t: result with nothing awaited, value %0d last %0b overflow %0b",
                             $time, $signed(value), last, overflow);
                end
                return;
            end
            exp_res = awaited.pop_front();
            if (value !== exp_res.value) begin
                flag("sorted_value", exp_res.value, value);
            end
            if (last !== exp_res.last) begin
                flag("last_out", 64'(exp_res.last), 64'(last));
            end
            if (overflow !== exp_res.overflow) begin
                flag("overflow", 64'(exp_res.overflow), 64'(overflow));
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic [DATA_W-1:0] s_value;
    logic              s_last_in;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_sorted_value;
    logic              m_last_out;
    logic              m_overflow;

    sort_scoreboard sb = new();

    int unsigned values_sent  = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;
    bit          sender_gappy = 1'b1;

    // Receiver pattern state.
    int unsigned rx_cycle   = 0;
    int unsigned rx_mode    = 0;
    int unsigned stall_left = 0;

    integer_run_sorter_unit #(
        .MAX_ITEMS(RUN_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_out    (m_last_out),
        .m_overflow    (m_overflow)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog: stops the test with a failure once the cycle counter reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results awaited",
                     cycle_count, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver's stall pattern is redrawn at random from four: always ready,
    // coin toss, a fixed five-in-eight duty cycle, or occasional long stalls.
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= (rx_cycle % 8) < 5;
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(5, 20);
                    end
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // Every result transfer is checked at the rising edge on which it happens.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            sb.check_result(m_sorted_value, m_last_out, m_overflow);
        end
    end

    // Presents one value at a falling edge and holds it until its transfer.
    // Valid is left high; the caller lowers it when a gap follows.
    task automatic send_value(input logic [DATA_W-1:0] value, input logic last);
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_value   <= value;
        s_last_in <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(value, last);
        values_sent++;
    endtask

    task automatic idle_sender(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // The sender works in bursts; in gappy stretches a random gap separates
    // one burst from the next, otherwise the bursts run back to back.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gappy) begin
                idle_sender($urandom_range(1, 6));
            end
        end
    endtask

    // Holds the sender back until every awaited result has been transferred.
    task automatic drain_results();
        idle_sender(1);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // The order register is only written while the sorter is idle. The row is
    // already empty once the last result has left, so the quiet cycles before
    // the write are only a margin.
    task automatic set_order(input logic order);
        drain_results();
        repeat (RUN_DEPTH + 8) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.descending = order;
    endtask

    // Half full-width random patterns, the rest extremes, small signed values
    // and repeats of the previous value, mixed in so that ties occur.
    function automatic logic [DATA_W-1:0] pick_value(logic [DATA_W-1:0] prev);
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return prev;
            3, 4:    return 64'($urandom_range(0, 16)) - 64'd8;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Corner values in one run, a run of a single value, and a run with ties.
    task automatic directed_runs();
        int k;
        for (k = 0; k < 8; k++) begin
            send_value(CORNER_VALUES[k], k == 7);
            pace_sender();
        end
        send_value(-64'sd5, 1'b1);
        pace_sender();
        for (k = 0; k < 4; k++) begin
            send_value((k == 2) ? -64'sd7 : 64'sd7, k == 3);
            pace_sender();
        end
    endtask

    task automatic random_run(input int unsigned len);
        logic [DATA_W-1:0] value;
        int unsigned       k;
        value = '0;
        for (k = 0; k < len; k++) begin
            value = pick_value(value);
            send_value(value, k == len - 1);
            pace_sender();
        end
    endtask

    initial begin
        int unsigned run_no;
        int unsigned phase_start;
        int unsigned len;
        int          phase;
        logic        order;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = ORDER_ASCENDING;
        s_valid     = 1'b0;
        s_value     = '0;
        s_last_in   = 1'b0;
        run_no      = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_order(ORDER_ASCENDING);
        directed_runs();
        set_order(ORDER_DESCENDING);
        directed_runs();

        // Random phases: both orders explicitly, then random settings. Most
        // runs are short; every ninth run is close to the capacity and some
        // go well past it, so the dropped-value path is exercised often.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 2) begin
                order = (phase == 0) ? ORDER_ASCENDING : ORDER_DESCENDING;
            end else begin
                order = 1'($urandom_range(0, 1));
            end
            set_order(order);
            phase_start = values_sent;
            while (values_sent - phase_start < PHASE_SIZE) begin
                if (run_no % 9 == 4) begin
                    len = $urandom_range(RUN_DEPTH - 1, RUN_DEPTH + 2);
                end else if (run_no % 17 == 8) begin
                    len = $urandom_range(RUN_DEPTH + 3, RUN_DEPTH + 16);
                end else begin
                    len = $urandom_range(1, 12);
                end
                sender_gappy = ($urandom_range(0, 3) != 0);
                random_run(len);
                run_no++;
                if ($urandom_range(0, 9) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (RUN_DEPTH + 16) @(posedge aclk);

        $display("Sent %0d values in %0d runs, %0d of them over capacity, in both sort orders.",
                 values_sent, sb.runs_closed, sb.overflow_runs);
        $display("Checked %0d sorted results, %0d failures, %0d results still awaited.",
                 sb.results_checked, sb.failures, sb.pending());
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule : testbench
`default_nettype wire

### filelist.f
design/irs_pkg.sv
design/irs_cell.sv
design/integer_run_sorter_unit.sv
verif/testbench.sv
